// ===== rtl/sacd_pkg.sv =====
// shared op codes, defaults and result type for the cache tag directory
`timescale 1ns / 1ps
package sacd_pkg;

  localparam int SetBitsDef   = 10;
  localparam int BlockBitsDef = 6;
  localparam int NumWaysDef   = 8;
  localparam int AddrBitsDef  = 32;

  localparam int OpW    = 2;
  localparam int WayW   = 3;
  localparam int PAddrW = 32;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL       = 2'd1,
    OP_MARK_DIRTY = 2'd2
  } op_t;

  typedef struct packed {
    logic              hit;
    logic [WayW-1:0]   way;
    logic              wb_needed;
    logic [PAddrW-1:0] wb_addr;
  } result_t;

endpackage

// ===== rtl/sacd_set_update.sv =====
// per-set hit search, victim choice, lru refresh and row rewrite
`timescale 1ns / 1ps
module sacd_set_update
  import sacd_pkg::*;
#(
  parameter int SET_BITS   = SetBitsDef,
  parameter int BLOCK_BITS = BlockBitsDef,
  parameter int NUM_WAYS   = NumWaysDef,
  parameter int TAG_W      = 16,
  parameter int AGE_W      = 3,
  parameter int ENT_W      = 2 + TAG_W + AGE_W
) (
  input  logic [OpW-1:0]            op,
  input  logic [SET_BITS-1:0]       set_idx,
  input  logic [TAG_W-1:0]          tag,
  input  logic [WayW-1:0]           way_in,
  input  logic [NUM_WAYS*ENT_W-1:0] row_in,
  output logic [NUM_WAYS*ENT_W-1:0] row_out,
  output logic                      wr_en,
  output result_t                   res
);

  localparam int VB = AGE_W + TAG_W + 1;
  localparam int DB = AGE_W + TAG_W;
  localparam int SH = SET_BITS + BLOCK_BITS;

  logic             vld   [NUM_WAYS];
  logic             dty   [NUM_WAYS];
  logic [TAG_W-1:0] tg    [NUM_WAYS];
  logic [AGE_W-1:0] age   [NUM_WAYS];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      vld[w] = row_in[w*ENT_W + VB];
      dty[w] = row_in[w*ENT_W + DB];
      tg[w]  = row_in[w*ENT_W + AGE_W +: TAG_W];
      age[w] = row_in[w*ENT_W +: AGE_W];
    end
  end

  logic             hit_found;
  logic [AGE_W-1:0] hit_way;
  logic             inv_found;
  logic [AGE_W-1:0] inv_way;
  logic [AGE_W-1:0] vic_way;
  logic [AGE_W-1:0] vic_age;

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    vic_way   = '0;
    vic_age   = age[0];
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit_found && vld[w] && tg[w] == tag) begin
        hit_found = 1'b1;
        hit_way   = AGE_W'(w);
      end
      if (!inv_found && !vld[w]) begin
        inv_found = 1'b1;
        inv_way   = AGE_W'(w);
      end
      // strict compare keeps the first of equal ages
      if (age[w] > vic_age) begin
        vic_age = age[w];
        vic_way = AGE_W'(w);
      end
    end
  end

  logic [AGE_W-1:0] sel_way;
  logic             touch;
  logic             do_fill;
  logic             evict_dirty;
  logic [TAG_W-1:0] evict_tag;
  logic [63:0]      wb_full;

  always_comb begin
    sel_way     = '0;
    touch       = 1'b0;
    do_fill     = 1'b0;
    wr_en       = 1'b0;
    res         = '0;
    evict_dirty = 1'b0;
    evict_tag   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (vic_way == AGE_W'(w)) begin
        evict_dirty = dty[w];
        evict_tag   = tg[w];
      end
    end
    wb_full = (64'(evict_tag) << SH) | (64'(set_idx) << BLOCK_BITS);
    unique case (op)
      OP_LOOKUP: begin
        if (hit_found) begin
          sel_way = hit_way;
          touch   = 1'b1;
          wr_en   = 1'b1;
          res.hit = 1'b1;
          res.way = WayW'(hit_way);
        end
      end
      OP_FILL: begin
        sel_way = inv_found ? inv_way : vic_way;
        touch   = 1'b1;
        do_fill = 1'b1;
        wr_en   = 1'b1;
        res.hit = 1'b1;
        res.way = WayW'(sel_way);
        if (!inv_found && evict_dirty) begin
          res.wb_needed = 1'b1;
          res.wb_addr   = wb_full[PAddrW-1:0];
        end
      end
      OP_MARK_DIRTY: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic [AGE_W-1:0] old_age;

  always_comb begin
    old_age = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (sel_way == AGE_W'(w)) old_age = age[w];
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      logic             v_n;
      logic             d_n;
      logic [TAG_W-1:0] t_n;
      logic [AGE_W-1:0] a_n;
      v_n = vld[w];
      d_n = dty[w];
      t_n = tg[w];
      a_n = age[w];
      if (touch) begin
        if (sel_way == AGE_W'(w)) a_n = '0;
        else if (age[w] < old_age) a_n = age[w] + AGE_W'(1);
      end
      if (do_fill && sel_way == AGE_W'(w)) begin
        v_n = 1'b1;
        d_n = 1'b0;
        t_n = tag;
      end
      // ways beyond the configured count never match
      if (op == OP_MARK_DIRTY && int'(way_in) == w) d_n = 1'b1;
      row_out[w*ENT_W +: ENT_W] = {v_n, d_n, t_n, a_n};
    end
  end

endmodule

// ===== rtl/set_assoc_cache_directory_lru.sv =====
// top level: set row memory, read-modify-write pipeline and reset clearing pass
// pipeline: an accepted item has its row read into the stage 1 registers, then its
// result and out_valid are registered together from the update logic
// throughput: one item per cycle while busy is low; back-to-back items on one set use the forwarded row
// reset: after rst_n the memory is swept one set per cycle, from set 0 to the last,
// busy high meanwhile; results cannot be stalled, out_valid marks each one cycle
`timescale 1ns / 1ps
module set_assoc_cache_directory_lru
  import sacd_pkg::*;
#(
  parameter int SET_BITS   = SetBitsDef,
  parameter int BLOCK_BITS = BlockBitsDef,
  parameter int NUM_WAYS   = NumWaysDef,
  parameter int ADDR_BITS  = AddrBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OpW-1:0]    in_op,
  input  logic [PAddrW-1:0] in_address,
  input  logic [WayW-1:0]   in_way_in,
  output logic              out_valid,
  output logic              out_hit,
  output logic [WayW-1:0]   out_way_out,
  output logic              out_writeback_needed,
  output logic [PAddrW-1:0] out_writeback_addr
);

  localparam int SH      = SET_BITS + BLOCK_BITS;
  localparam bit HAS_TAG = ADDR_BITS > SH;
  localparam int TAG_W   = HAS_TAG ? ADDR_BITS - SH : 1;
  localparam int AGE_W   = $clog2(NUM_WAYS);
  localparam int ENT_W   = 2 + TAG_W + AGE_W;
  localparam int ROW_W   = NUM_WAYS * ENT_W;
  localparam int NSETS   = 1 << SET_BITS;

  logic [ROW_W-1:0] mem [NSETS];

  logic                clearing_r;
  logic [SET_BITS-1:0] clr_cnt_r;
  logic                accept;
  logic [SET_BITS-1:0] in_set;
  logic [TAG_W-1:0]    in_tag;
  logic [63:0]         addr_ext;

  assign busy     = clearing_r;
  assign accept   = start && !clearing_r;
  assign in_set   = in_address[BLOCK_BITS +: SET_BITS];
  assign addr_ext = 64'(in_address);
  assign in_tag   = HAS_TAG ? TAG_W'(addr_ext >> SH) : '0;

  logic [ROW_W-1:0] clear_row;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      clear_row[w*ENT_W +: ENT_W] = {1'b0, 1'b0, {TAG_W{1'b0}}, AGE_W'(w)};
    end
  end

  // stage 1: item whose row is being read
  logic                s1_vld_r;
  logic [OpW-1:0]      s1_op_r;
  logic [SET_BITS-1:0] s1_set_r;
  logic [TAG_W-1:0]    s1_tag_r;
  logic [WayW-1:0]     s1_way_r;
  logic [ROW_W-1:0]    rd_row_r;

  // last row produced, covers a write landing on the same edge as the next read
  logic                fw_vld_r;
  logic [SET_BITS-1:0] fw_set_r;
  logic [ROW_W-1:0]    fw_row_r;

  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] row_nxt;
  logic             upd_wr;
  result_t          res_nxt;
  result_t          res_r;
  logic             out_valid_r;

  assign cur_row = (fw_vld_r && fw_set_r == s1_set_r) ? fw_row_r : rd_row_r;

  sacd_set_update #(
    .SET_BITS  (SET_BITS),
    .BLOCK_BITS(BLOCK_BITS),
    .NUM_WAYS  (NUM_WAYS),
    .TAG_W     (TAG_W),
    .AGE_W     (AGE_W),
    .ENT_W     (ENT_W)
  ) u_update (
    .op     (s1_op_r),
    .set_idx(s1_set_r),
    .tag    (s1_tag_r),
    .way_in (s1_way_r),
    .row_in (cur_row),
    .row_out(row_nxt),
    .wr_en  (upd_wr),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (accept) rd_row_r <= mem[in_set];
    if (clearing_r) begin
      mem[clr_cnt_r] <= clear_row;
    end else if (s1_vld_r && upd_wr) begin
      mem[s1_set_r] <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      fw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + SET_BITS'(1);
        if (clr_cnt_r == {SET_BITS{1'b1}}) clearing_r <= 1'b0;
      end
      s1_vld_r    <= accept;
      fw_vld_r    <= s1_vld_r;
      out_valid_r <= s1_vld_r;
    end
    if (accept) begin
      s1_op_r  <= in_op;
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
      s1_way_r <= in_way_in;
    end
    if (s1_vld_r) begin
      fw_set_r <= s1_set_r;
      fw_row_r <= row_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = res_r.hit;
  assign out_way_out          = res_r.way;
  assign out_writeback_needed = res_r.wb_needed;
  assign out_writeback_addr   = res_r.wb_addr;

endmodule

// ===== tb/tb_set_assoc_cache_directory_lru.sv =====
// self-checking testbench for the set-associative cache tag directory with lru replacement
`timescale 1ns / 1ps
module tb_set_assoc_cache_directory_lru;
  import sacd_pkg::*;

  localparam int NumSets  = 1 << SetBitsDef;
  localparam int TagW     = AddrBitsDef - SetBitsDef - BlockBitsDef;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int NumRandom = 1250;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [PAddrW-1:0] address;
    logic [WayW-1:0]   way_in;
  } access_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OpW-1:0]    in_op = '0;
  logic [PAddrW-1:0] in_address = '0;
  logic [WayW-1:0]   in_way_in = '0;
  logic              out_valid;
  logic              out_hit;
  logic [WayW-1:0]   out_way_out;
  logic              out_writeback_needed;
  logic [PAddrW-1:0] out_writeback_addr;

  // predicted directory contents
  bit                line_valid [NumSets][NumWaysDef];
  bit                line_dirty [NumSets][NumWaysDef];
  logic [TagW-1:0]   line_tag   [NumSets][NumWaysDef];
  int unsigned       lru_age    [NumSets][NumWaysDef];

  access_t pending_accesses[$];
  result_t expected_results[$];
  int      total_accesses;
  int      n_sent;
  int      n_checked;
  int      n_hits;
  int      n_writebacks;
  int      n_errors;

  set_assoc_cache_directory_lru dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_address          (in_address),
    .in_way_in           (in_way_in),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_way_out         (out_way_out),
    .out_writeback_needed(out_writeback_needed),
    .out_writeback_addr  (out_writeback_addr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void refresh_lru(int s, int w);
    int unsigned old_age;
    old_age = lru_age[s][w];
    for (int i = 0; i < NumWaysDef; i++) begin
      if (lru_age[s][i] < old_age) lru_age[s][i]++;
    end
    lru_age[s][w] = 0;
  endfunction

  // applies one access to the predicted directory and returns its result
  function automatic result_t directory_access(access_t a);
    result_t         r;
    int              s;
    int              w;
    logic [TagW-1:0] t;
    r = '0;
    s = int'(a.address[BlockBitsDef +: SetBitsDef]);
    t = a.address[AddrBitsDef-1 -: TagW];
    case (a.op)
      OP_LOOKUP: begin
        for (int i = 0; i < NumWaysDef; i++) begin
          if (!r.hit && line_valid[s][i] && line_tag[s][i] == t) begin
            r.hit = 1'b1;
            r.way = WayW'(i);
            refresh_lru(s, i);
          end
        end
      end
      OP_FILL: begin
        w = -1;
        for (int i = 0; i < NumWaysDef; i++) begin
          if (w < 0 && !line_valid[s][i]) w = i;
        end
        if (w < 0) begin
          // oldest way, first one on a tie
          w = 0;
          for (int i = 1; i < NumWaysDef; i++) begin
            if (lru_age[s][i] > lru_age[s][w]) w = i;
          end
          if (line_dirty[s][w]) begin
            r.wb_needed = 1'b1;
            r.wb_addr   = {line_tag[s][w], SetBitsDef'(s), {BlockBitsDef{1'b0}}};
          end
        end
        line_tag[s][w]   = t;
        line_valid[s][w] = 1'b1;
        line_dirty[s][w] = 1'b0;
        refresh_lru(s, w);
        r.hit = 1'b1;
        r.way = WayW'(w);
      end
      OP_MARK_DIRTY: begin
        if (int'(a.way_in) < NumWaysDef) line_dirty[s][a.way_in] = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [PAddrW-1:0] make_addr(logic [TagW-1:0] t,
                                                  logic [SetBitsDef-1:0] s,
                                                  logic [BlockBitsDef-1:0] off);
    return {t, s, off};
  endfunction

  function automatic void queue_access(logic [OpW-1:0] op, logic [PAddrW-1:0] addr,
                                       logic [WayW-1:0] way);
    access_t a;
    a.op      = op;
    a.address = addr;
    a.way_in  = way;
    pending_accesses.push_back(a);
  endfunction

  // driver: sender gaps depend on which third of the run we are in
  always @(posedge clk) begin
    access_t     a;
    bit          taken;
    int unsigned idle_pct;
    taken = rst_n && start && !busy;
    if (taken) begin
      a.op      = in_op;
      a.address = in_address;
      a.way_in  = in_way_in;
      expected_results.push_back(directory_access(a));
      n_sent++;
    end
    if (n_sent * 3 < total_accesses) idle_pct = 36;
    else if (n_sent * 3 < total_accesses * 2) idle_pct = 47;
    else idle_pct = 0;
    if (rst_n && (!start || taken)) begin
      if (pending_accesses.size() != 0 && $urandom_range(99) >= idle_pct) begin
        a = pending_accesses.pop_front();
        in_op      <= a.op;
        in_address <= a.address;
        in_way_in  <= a.way_in;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is one result transfer
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: hit=%0d way=%0d wb=%0d wb_addr=%h",
               out_hit, out_way_out, out_writeback_needed, out_writeback_addr);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (out_hit && out_writeback_needed === 1'b0) n_hits++;
        if (out_writeback_needed) n_writebacks++;
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_hit);
          n_errors++;
        end
        if (out_way_out !== e.way) begin
          $error("way_out: expected %0d, got %0d", e.way, out_way_out);
          n_errors++;
        end
        if (out_writeback_needed !== e.wb_needed) begin
          $error("writeback_needed: expected %0d, got %0d", e.wb_needed,
                 out_writeback_needed);
          n_errors++;
        end
        if (out_writeback_addr !== e.wb_addr) begin
          $error("writeback_addr: expected %h, got %h", e.wb_addr, out_writeback_addr);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [SetBitsDef-1:0] set_pool [8];
    logic [TagW-1:0]       tag_pool [12];
    logic [TagW-1:0]       fill_tags [NumWaysDef];
    logic [SetBitsDef-1:0] s;
    logic [OpW-1:0]        op;
    logic [PAddrW-1:0]     addr;
    int unsigned           pick;

    for (int sidx = 0; sidx < NumSets; sidx++) begin
      for (int w = 0; w < NumWaysDef; w++) begin
        line_valid[sidx][w] = 1'b0;
        line_dirty[sidx][w] = 1'b0;
        line_tag[sidx][w]   = '0;
        lru_age[sidx][w]    = w;
      end
    end

    // directed: misses on empty sets, unused op, dirty mark on an invalid line,
    // filling a set, dirty evictions with extreme tags and set index
    queue_access(OP_LOOKUP, 32'h0000_0000, 3'd0);
    queue_access(OpUnused, 32'hFFFF_FFFF, 3'd7);
    queue_access(OP_MARK_DIRTY, 32'h0000_0000, 3'd7);
    fill_tags[0] = 16'h1234;
    fill_tags[1] = 16'hFFFF;
    fill_tags[2] = 16'h0000;
    for (int w = 3; w < NumWaysDef; w++) fill_tags[w] = TagW'(16'h8000 | (w * 16'h1111));
    for (int w = 0; w < NumWaysDef; w++) begin
      queue_access(OP_FILL, make_addr(fill_tags[w], '1, 6'(w * 9)), 3'd0);
    end
    queue_access(OP_LOOKUP, make_addr(fill_tags[0], '1, 6'h3F), 3'd0);
    queue_access(OP_MARK_DIRTY, make_addr(16'h5555, '1, 6'h00), 3'd1);
    queue_access(OP_FILL, make_addr(16'hA5A5, '1, 6'h15), 3'd0);
    queue_access(OP_MARK_DIRTY, make_addr(16'h0F0F, '1, 6'h2A), 3'd2);
    queue_access(OP_FILL, make_addr(16'h5A5A, '1, 6'h3F), 3'd0);
    queue_access(OP_LOOKUP, make_addr(16'hFFFF, '1, 6'h00), 3'd0);
    queue_access(OP_LOOKUP, 32'hFFFF_FFFF, 3'd7);
    queue_access(OP_FILL, 32'hFFFF_FFFF, 3'd0);
    queue_access(OpUnused, 32'h0000_0000, 3'd0);

    // random: a few hot sets and a tag pool larger than the ways, so sets fill
    // up and evict; some fully random addresses on top
    for (int i = 0; i < 8; i++) set_pool[i] = SetBitsDef'($urandom);
    for (int i = 0; i < 12; i++) tag_pool[i] = TagW'($urandom);
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_LOOKUP;
      else if (pick < 70) op = OP_FILL;
      else if (pick < 93) op = OP_MARK_DIRTY;
      else op = OpUnused;
      if ($urandom_range(99) < 85) begin
        s = set_pool[$urandom_range(7)];
        addr = make_addr(tag_pool[$urandom_range(11)], s, BlockBitsDef'($urandom));
      end else begin
        addr = $urandom;
      end
      queue_access(op, addr, WayW'($urandom_range(NumWaysDef - 1)));
    end
    total_accesses = pending_accesses.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_errors++;
    end
    $display("%0d accesses sent, %0d results checked", n_sent, n_checked);
    $display("%0d hits or fills without eviction writeback, %0d dirty writebacks",
             n_hits, n_writebacks);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule
